// ===== rtl/core/debp_pkg.sv =====
// package with phases, record codes and result type for the event bitstream parser
package debp_pkg;

   typedef enum logic [4:0] {
      PH_HUNT0, PH_HUNT, PH_TIME, PH_DELTA, PH_START, PH_HDR, PH_LAYER,
      PH_CHIP, PH_NSTRIP, PH_FIRST, PH_BOARD, PH_PED, PH_PULSE, PH_SKIP,
      PH_SCNT, PH_SAMP
   } phase_type;

   localparam logic [3:0] REC_TIMETAG  = 4'd0;
   localparam logic [3:0] REC_DELTA    = 4'd1;
   localparam logic [3:0] REC_EVTHDR   = 4'd2;
   localparam logic [3:0] REC_LAYER    = 4'd3;
   localparam logic [3:0] REC_CHIP     = 4'd4;
   localparam logic [3:0] REC_CLUSTER  = 4'd5;
   localparam logic [3:0] REC_BOARD    = 4'd6;
   localparam logic [3:0] REC_PEDESTAL = 4'd7;
   localparam logic [3:0] REC_PULSE    = 4'd8;
   localparam logic [3:0] REC_SAMPLE   = 4'd9;
   localparam logic [3:0] REC_FRAMING  = 4'd10;
   localparam logic [3:0] REC_EOD      = 4'd11;
   localparam logic [3:0] REC_SYNC     = 4'd12;

   localparam logic [1:0] CSR_SYNC_WORD   = 2'd0;
   localparam logic [1:0] CSR_ZERO_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_CLUSTER_CAP = 2'd2;

   localparam logic [23:0] SYNC_RESET  = 24'hF04354;
   localparam logic [3:0]  ZLIM_RESET  = 4'd3;
   localparam logic [3:0]  CCAP_RESET  = 4'd10;
   localparam logic [3:0]  BOARD_BASE  = 4'd12;

   typedef struct packed {
      logic [3:0]  record_kind;
      logic [35:0] value;
      logic [15:0] signed_value;
      logic [4:0]  count;
      logic [3:0]  address;
      logic [3:0]  flags;
      logic [3:0]  section;
      logic [3:0]  chip_slot;
      logic [4:0]  item;
      logic [1:0]  channel;
      logic        last;
   } record_type;

   function automatic logic [5:0] field_len(input phase_type ph);
      unique case (ph)
         PH_HUNT0:  field_len = 6'd24;
         PH_HUNT:   field_len = 6'd4;
         PH_TIME:   field_len = 6'd36;
         PH_DELTA:  field_len = 6'd12;
         PH_START:  field_len = 6'd2;
         PH_HDR:    field_len = 6'd22;
         PH_LAYER:  field_len = 6'd12;
         PH_CHIP:   field_len = 6'd12;
         PH_NSTRIP: field_len = 6'd6;
         PH_FIRST:  field_len = 6'd6;
         PH_BOARD:  field_len = 6'd12;
         PH_PED:    field_len = 6'd8;
         PH_PULSE:  field_len = 6'd16;
         PH_SKIP:   field_len = 6'd4;
         PH_SCNT:   field_len = 6'd3;
         PH_SAMP:   field_len = 6'd15;
         default:   field_len = 6'd24;
      endcase
   endfunction

endpackage

// ===== rtl/core/debp_out_stage.sv =====
// output register with skid stage for result records
module debp_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  debp_pkg::record_type in_rec,
   output logic                out_valid,
   input  logic                out_ready,
   output debp_pkg::record_type out_rec
);
   import debp_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   record_type main_ff, main_in;
   record_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_rec   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_rec;
            main_valid_in = in_valid;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_in       = in_rec;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== rtl/core/debp_parser.sv =====
// bit-serial hunt and field decode state machine
module debp_parser #(
   parameter int TRACKER_LAYERS = 12,
   parameter int ENERGY_BOARDS  = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 bit_valid,
   input  logic                 bit_in,
   input  logic [23:0]          sync_word,
   input  logic [3:0]           zero_limit,
   input  logic [3:0]           cluster_cap,
   output logic                 rec_valid,
   output debp_pkg::record_type rec
);
   import debp_pkg::*;

   localparam logic [3:0] LAYERS_C = 4'(TRACKER_LAYERS);
   localparam logic [3:0] BOARDS_C = 4'(ENERGY_BOARDS);

   phase_type   phase_ff, phase_in;
   logic [5:0]  bit_count_ff, bit_count_in;
   logic [35:0] shifter_ff, shifter_in;
   logic [23:0] hunt_ff, hunt_in;
   logic [3:0]  zero_ff, zero_in;
   logic [3:0]  sect_ff, sect_in;
   logic [3:0]  chip_ff, chip_in;
   logic [3:0]  chip_total_ff, chip_total_in;
   logic [4:0]  item_ff, item_in;
   logic [4:0]  item_total_ff, item_total_in;
   logic [1:0]  chan_ff, chan_in;
   logic [1:0]  mode_ff, mode_in;
   logic        stop_ff, stop_in;

   logic [35:0] s;
   logic [5:0]  cnt;
   logic        done;
   logic [3:0]  tmp4, tag5lo;
   logic [4:0]  tag, ns;
   logic        red, err, peds;

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shifter_in    = shifter_ff;
      hunt_in       = hunt_ff;
      zero_in       = zero_ff;
      sect_in       = sect_ff;
      chip_in       = chip_ff;
      chip_total_in = chip_total_ff;
      item_in       = item_ff;
      item_total_in = item_total_ff;
      chan_in       = chan_ff;
      mode_in       = mode_ff;
      stop_in       = stop_ff;
      rec_valid     = 1'b0;
      rec           = '0;
      s             = {shifter_ff[34:0], bit_in};
      cnt           = bit_count_ff + 6'd1;
      done          = cnt >= field_len(phase_ff);
      tmp4          = '0;
      tag           = s[11:7];
      tag5lo        = tag[3:0];
      red           = s[6];
      err           = s[5];
      ns            = s[4:0];
      peds          = 1'b0;

      if (bit_valid && !stop_ff) begin
         if (phase_ff == PH_HUNT0 || phase_ff == PH_HUNT) begin
            hunt_in      = {hunt_ff[22:0], bit_in};
            bit_count_in = cnt;
            if (done) begin
               bit_count_in = '0;
               if (hunt_in == sync_word) begin
                  rec_valid       = 1'b1;
                  rec.record_kind = REC_SYNC;
                  rec.value       = {12'd0, hunt_in};
                  phase_in        = PH_TIME;
                  shifter_in      = '0;
               end else if (phase_ff == PH_HUNT0) begin
                  phase_in = PH_HUNT;
                  zero_in  = '0;
               end else if (hunt_in[7:0] == 8'd0) begin
                  if (zero_ff >= zero_limit) begin
                     rec_valid       = 1'b1;
                     rec.record_kind = REC_EOD;
                     stop_in         = 1'b1;
                  end else begin
                     zero_in = zero_ff + 4'd1;
                  end
               end
            end
         end else begin
            shifter_in   = s;
            bit_count_in = cnt;
            if (done) begin
               bit_count_in = '0;
               shifter_in   = '0;
               unique case (phase_ff)
                  PH_TIME: begin
                     rec_valid = 1'b1; rec.record_kind = REC_TIMETAG; rec.value = s;
                     phase_in = PH_DELTA;
                  end
                  PH_DELTA: begin
                     rec_valid = 1'b1; rec.record_kind = REC_DELTA;
                     rec.value = {24'd0, s[11:0]};
                     phase_in = PH_START;
                  end
                  PH_START: begin
                     if (s[1:0] == 2'b10) begin
                        phase_in = PH_HDR;
                     end else begin
                        rec_valid = 1'b1; rec.record_kind = REC_FRAMING;
                        rec.value = {34'd0, s[1:0]}; rec.last = 1'b1;
                        phase_in = PH_HUNT0; bit_count_in = '0;
                        hunt_in = '0; zero_in = '0;
                     end
                  end
                  PH_HDR: begin
                     rec_valid = 1'b1; rec.record_kind = REC_EVTHDR;
                     rec.value = {18'd0, s[17:0]}; rec.flags = s[21:18];
                     sect_in = '0; phase_in = PH_LAYER;
                  end
                  PH_LAYER: begin
                     rec_valid = 1'b1; rec.record_kind = REC_LAYER;
                     rec.value = {33'd0, s[7:5]}; rec.count = {1'b0, s[3:0]};
                     rec.address = s[11:8]; rec.flags = {3'd0, s[4]};
                     rec.section = sect_ff;
                     chip_total_in = s[3:0]; chip_in = '0;
                     if (s[3:0] != 4'd0) begin
                        phase_in = PH_CHIP;
                     end else begin
                        tmp4 = sect_ff + 4'd1;
                        if (tmp4 < LAYERS_C) begin
                           sect_in = tmp4; phase_in = PH_LAYER;
                        end else begin
                           sect_in = '0; phase_in = PH_BOARD;
                        end
                     end
                  end
                  PH_CHIP, PH_FIRST: begin
                     rec_valid = 1'b1;
                     rec.section = sect_ff; rec.chip_slot = chip_ff;
                     if (phase_ff == PH_CHIP) begin
                        rec.record_kind = REC_CHIP;
                        rec.count = {1'b0, s[9:6]}; rec.address = s[3:0];
                        rec.flags = {1'b0, s[11], s[5], s[4]};
                        item_total_in = {1'b0, (s[9:6] < cluster_cap) ? s[9:6] : cluster_cap};
                        item_in = '0;
                     end else begin
                        rec.record_kind = REC_CLUSTER;
                        rec.value = {30'd0, s[5:0]}; rec.item = item_ff; rec.channel = 2'd1;
                        item_in = item_ff + 5'd1;
                        item_total_in = item_total_ff;
                     end
                     if (item_in < item_total_in) begin
                        phase_in = PH_NSTRIP;
                     end else begin
                        chip_in = chip_ff + 4'd1;
                        if (chip_in < chip_total_ff && chip_in != 4'd0) begin
                           phase_in = PH_CHIP;
                        end else begin
                           tmp4 = sect_ff + 4'd1;
                           if (tmp4 < LAYERS_C) begin
                              sect_in = tmp4; phase_in = PH_LAYER;
                           end else begin
                              sect_in = '0; phase_in = PH_BOARD;
                           end
                        end
                     end
                  end
                  PH_NSTRIP: begin
                     rec_valid = 1'b1; rec.record_kind = REC_CLUSTER;
                     rec.value = {30'd0, s[5:0]} + 36'd1;
                     rec.section = sect_ff; rec.chip_slot = chip_ff; rec.item = item_ff;
                     phase_in = PH_FIRST;
                  end
                  PH_BOARD: begin
                     peds = red & tag[4];
                     rec_valid = 1'b1; rec.record_kind = REC_BOARD;
                     rec.value = {31'd0, red ? {1'b0, tag5lo} : tag};
                     rec.flags = {red, peds, err, 1'b0};
                     rec.section = BOARD_BASE + sect_ff;
                     item_in = '0; chan_in = '0; mode_in = {red, peds};
                     tmp4 = sect_ff + 4'd1;
                     if (ns == 5'd0) begin
                        item_total_in = '0;
                        sect_in = tmp4;
                        if (tmp4 < BOARDS_C) phase_in = PH_BOARD;
                        else begin
                           phase_in = PH_HUNT0; hunt_in = '0; zero_in = '0;
                           rec.last = 1'b1;
                        end
                     end else if (red) begin
                        item_total_in = {3'd0, ns[4:3]};
                        rec.count = {3'd0, ns[4:3]}; rec.address = {1'b0, ns[2:0]};
                        if (ns[4:3] == 2'd0) begin
                           sect_in = tmp4;
                           if (tmp4 < BOARDS_C) phase_in = PH_BOARD;
                           else begin
                              phase_in = PH_HUNT0; hunt_in = '0; zero_in = '0;
                              rec.last = 1'b1;
                           end
                        end else begin
                           phase_in = peds ? PH_PED : PH_PULSE;
                        end
                     end else begin
                        item_total_in = ns; rec.count = ns; phase_in = PH_SCNT;
                     end
                  end
                  PH_PED: begin
                     rec_valid = 1'b1; rec.record_kind = REC_PEDESTAL;
                     rec.signed_value = {{8{s[7]}}, s[7:0]};
                     rec.section = BOARD_BASE + sect_ff; rec.item = item_ff;
                     phase_in = PH_PULSE;
                  end
                  PH_PULSE: begin
                     rec_valid = 1'b1; rec.record_kind = REC_PULSE;
                     rec.signed_value = s[15:0];
                     rec.section = BOARD_BASE + sect_ff; rec.item = item_ff;
                     item_in = item_ff + 5'd1;
                     tmp4 = sect_ff + 4'd1;
                     if (item_in < item_total_ff) begin
                        phase_in = mode_ff[0] ? PH_PED : PH_PULSE;
                     end else if (item_total_ff == 5'd2 && !mode_ff[0]) begin
                        phase_in = PH_SKIP;
                        rec.last = (sect_ff == BOARDS_C - 4'd1);
                     end else begin
                        sect_in = tmp4;
                        if (tmp4 < BOARDS_C) phase_in = PH_BOARD;
                        else begin
                           phase_in = PH_HUNT0; hunt_in = '0; zero_in = '0;
                           rec.last = 1'b1;
                        end
                     end
                  end
                  PH_SKIP, PH_SCNT: begin
                     if (phase_ff == PH_SCNT) begin
                        chan_in = '0; phase_in = PH_SAMP;
                     end else begin
                        tmp4 = sect_ff + 4'd1; sect_in = tmp4;
                        if (tmp4 < BOARDS_C) phase_in = PH_BOARD;
                        else begin
                           phase_in = PH_HUNT0; hunt_in = '0; zero_in = '0;
                        end
                     end
                  end
                  PH_SAMP: begin
                     rec_valid = 1'b1; rec.record_kind = REC_SAMPLE;
                     rec.signed_value = {{2{s[13]}}, s[13:0]};
                     rec.flags = {3'd0, s[14]};
                     rec.section = BOARD_BASE + sect_ff; rec.item = item_ff;
                     rec.channel = chan_ff;
                     chan_in = chan_ff + 2'd1;
                     if (chan_in == 2'd3) begin
                        chan_in = '0;
                        item_in = item_ff + 5'd1;
                        if (item_in < item_total_ff) phase_in = PH_SCNT;
                        else begin
                           tmp4 = sect_ff + 4'd1; sect_in = tmp4;
                           if (tmp4 < BOARDS_C) phase_in = PH_BOARD;
                           else begin
                              phase_in = PH_HUNT0; hunt_in = '0; zero_in = '0;
                              rec.last = 1'b1;
                           end
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_HUNT0; bit_count_in = '0; hunt_in = '0; zero_in = '0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT0;
         bit_count_ff  <= '0;
         shifter_ff    <= '0;
         hunt_ff       <= '0;
         zero_ff       <= '0;
         sect_ff       <= '0;
         chip_ff       <= '0;
         chip_total_ff <= '0;
         item_ff       <= '0;
         item_total_ff <= '0;
         chan_ff       <= '0;
         mode_ff       <= '0;
         stop_ff       <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shifter_ff    <= shifter_in;
         hunt_ff       <= hunt_in;
         zero_ff       <= zero_in;
         sect_ff       <= sect_in;
         chip_ff       <= chip_in;
         chip_total_ff <= chip_total_in;
         item_ff       <= item_in;
         item_total_ff <= item_total_in;
         chan_ff       <= chan_in;
         mode_ff       <= mode_in;
         stop_ff       <= stop_in;
      end
   end

endmodule

// ===== rtl/core/detector_event_bitstream_parser_core.sv =====
// top level of the detector event bitstream parser
// a completed record is registered in the output register (via the skid stage if rsp_ stalls)
// throughput: one bit per cycle while req_ready is high; parser state updates on every transfer
// the output register plus skid stage let a bit be taken while a record waits
// reset: synchronous; valid flags, parser state and CSRs return to their reset values and hunting restarts
// after end_of_data all bits are taken and dropped until reset
module detector_event_bitstream_parser_core #(
   parameter int TRACKER_LAYERS = 12,
   parameter int ENERGY_BOARDS  = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_bit_in,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [3:0]   rsp_record_kind,
   output logic [35:0]  rsp_value,
   output logic signed [15:0] rsp_signed_value,
   output logic [4:0]   rsp_count,
   output logic [3:0]   rsp_address,
   output logic [3:0]   rsp_flags,
   output logic [3:0]   rsp_section,
   output logic [3:0]   rsp_chip_slot,
   output logic [4:0]   rsp_item,
   output logic [1:0]   rsp_channel,
   output logic         rsp_last,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_write_data
);
   import debp_pkg::*;

   logic [23:0] sync_ff;
   logic [3:0]  zlim_ff, ccap_ff;
   logic        rec_valid;
   record_type  rec, out_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
         zlim_ff <= ZLIM_RESET;
         ccap_ff <= CCAP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SYNC_WORD:   sync_ff <= csr_write_data;
            CSR_ZERO_LIMIT:  zlim_ff <= csr_write_data[3:0];
            CSR_CLUSTER_CAP: ccap_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   debp_parser #(
      .TRACKER_LAYERS(TRACKER_LAYERS),
      .ENERGY_BOARDS (ENERGY_BOARDS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .bit_valid  (req_valid && req_ready),
      .bit_in     (req_bit_in),
      .sync_word  (sync_ff),
      .zero_limit (zlim_ff),
      .cluster_cap(ccap_ff),
      .rec_valid  (rec_valid),
      .rec        (rec)
   );

   debp_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rec_valid),
      .in_ready (req_ready),
      .in_rec   (rec),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_rec  (out_rec)
   );

   assign rsp_record_kind  = out_rec.record_kind;
   assign rsp_value        = out_rec.value;
   assign rsp_signed_value = out_rec.signed_value;
   assign rsp_count        = out_rec.count;
   assign rsp_address      = out_rec.address;
   assign rsp_flags        = out_rec.flags;
   assign rsp_section      = out_rec.section;
   assign rsp_chip_slot    = out_rec.chip_slot;
   assign rsp_item         = out_rec.item;
   assign rsp_channel      = out_rec.channel;
   assign rsp_last         = out_rec.last;

endmodule
